@@ sv/rrct_pkg.sv @@
// ----------------------------------------------------------------------------
// Round-robin completion times package
// Shared widths, the quantum reset value and memory record types.
// ----------------------------------------------------------------------------
package rrct_pkg;

    localparam int TIME_W        = 16;
    localparam int COMP_W        = 22;
    localparam int DIFF_W        = 23;
    localparam int INDEX_W       = 6;
    localparam int MAX_PROCS_DEF = 16;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(4);

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } job_rec_t;

    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [COMP_W-1:0] completion;
    } run_rec_t;

endpackage

@@ sv/round_robin_completion_times.sv @@
// ----------------------------------------------------------------------------
// Round-robin completion times
// Loads a set of jobs, simulates round-robin service and reports per-job times.
// ----------------------------------------------------------------------------
// Jobs are loaded at one transaction per cycle until the transaction marked
// last_item. The block then stops taking input and runs round-robin passes over
// the stored jobs; each pass reads every job's run record from the run memory
// in ST_PASS_RD, through a registered read, and writes it back in ST_PASS_WR.
// The number of passes is one more than the largest burst divided by the
// quantum, rounded up, because a final pass must find every job finished.
// Results follow, one job per result transaction in load order, each read in
// ST_OUT_RD and loaded in ST_OUT_LD, after which loading resumes; the final
// result may still be waiting on the output while the next set loads.
module round_robin_completion_times
    import rrct_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [TIME_W-1:0]         cfg_wdata,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TIME_W-1:0]         arrival_time,
    input  logic [TIME_W-1:0]         burst_time,
    input  logic                      last_item,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_W-1:0]        job_index,
    output logic [COMP_W-1:0]         completion_time,
    output logic signed [DIFF_W-1:0]  turnaround_time,
    output logic signed [DIFF_W-1:0]  waiting_time,
    output logic                      overflow,
    output logic                      last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_PASS_RD = 3'd1;
    localparam logic [2:0] ST_PASS_WR = 3'd2;
    localparam logic [2:0] ST_OUT_RD  = 3'd3;
    localparam logic [2:0] ST_OUT_LD  = 3'd4;

    job_rec_t job_mem [MAX_PROCS];
    run_rec_t run_mem [MAX_PROCS];
    job_rec_t job_rd;
    run_rec_t run_rd;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [COMP_W-1:0] clock_reg, clock_next;
    logic              dropped_reg, dropped_next;
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] quantum_reg;

    logic [INDEX_W-1:0]       job_index_reg;
    logic [COMP_W-1:0]        completion_reg;
    logic signed [DIFF_W-1:0] turnaround_reg;
    logic signed [DIFF_W-1:0] waiting_reg;
    logic                     overflow_reg;
    logic                     last_result_reg;

    logic              in_accept;
    logic              has_room;
    logic              at_last_job;
    logic              out_load;
    logic [TIME_W-1:0] q_eff;
    logic              job_live;
    run_rec_t          run_upd;
    logic [COMP_W-1:0] clock_upd;
    logic [DIFF_W-1:0] tat_calc;
    logic [DIFF_W-1:0] wt_calc;

    assign in_stall    = (state_reg != ST_LOAD);
    assign in_accept   = in_valid && !in_stall;
    assign has_room    = (count_reg < CNT_W'(MAX_PROCS));
    assign at_last_job = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign q_eff       = (quantum_reg == '0) ? TIME_W'(1) : quantum_reg;
    assign job_live    = (run_rd.remaining != '0);
    assign out_load    = (state_reg == ST_OUT_LD) && (!out_valid_reg || !out_stall);

    assign tat_calc = {1'b0, run_rd.completion} - DIFF_W'(job_rd.arrival);
    assign wt_calc  = tat_calc - DIFF_W'(job_rd.burst);

    always_comb
    begin
        run_upd   = run_rd;
        clock_upd = clock_reg;
        if (job_live)
        begin
            if (run_rd.remaining > q_eff)
            begin
                clock_upd         = clock_reg + COMP_W'(q_eff);
                run_upd.remaining = run_rd.remaining - q_eff;
            end
            else
            begin
                clock_upd          = clock_reg + COMP_W'(run_rd.remaining);
                run_upd.completion = clock_upd;
                run_upd.remaining  = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        clock_next     = clock_reg;
        dropped_next   = dropped_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (has_room)
                        count_next = count_reg + CNT_W'(1);
                    else
                        dropped_next = 1'b1;
                    if (last_item)
                    begin
                        state_next = ST_PASS_RD;
                        idx_next   = '0;
                        clock_next = '0;
                        busy_next  = 1'b0;
                    end
                end
            end
            ST_PASS_RD:
            begin
                state_next = ST_PASS_WR;
            end
            ST_PASS_WR:
            begin
                clock_next = clock_upd;
                if (at_last_job)
                begin
                    idx_next  = '0;
                    busy_next = 1'b0;
                    if (busy_reg || job_live)
                        state_next = ST_PASS_RD;
                    else
                        state_next = ST_OUT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    busy_next  = busy_reg || job_live;
                    state_next = ST_PASS_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (at_last_job)
                    begin
                        state_next   = ST_LOAD;
                        count_next   = '0;
                        clock_next   = '0;
                        dropped_next = 1'b0;
                        idx_next     = '0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            clock_reg     <= '0;
            dropped_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            quantum_reg   <= QUANTUM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clock_reg     <= clock_next;
            dropped_reg   <= dropped_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                quantum_reg <= cfg_wdata;
        end
    end

    // Job memory holds arrival and burst; run memory holds remaining and completion.
    always_ff @(posedge clk)
    begin
        if (in_accept && has_room)
            job_mem[count_reg[IDX_W-1:0]] <= '{arrival: arrival_time, burst: burst_time};
        job_rd <= job_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && has_room)
            run_mem[count_reg[IDX_W-1:0]] <= '{remaining: burst_time, completion: '0};
        else if (state_reg == ST_PASS_WR)
            run_mem[idx_reg] <= run_upd;
        run_rd <= run_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            job_index_reg   <= INDEX_W'(idx_reg);
            completion_reg  <= run_rd.completion;
            turnaround_reg  <= tat_calc;
            waiting_reg     <= wt_calc;
            overflow_reg    <= dropped_reg;
            last_result_reg <= at_last_job;
        end
    end

    assign out_valid       = out_valid_reg;
    assign job_index       = job_index_reg;
    assign completion_time = completion_reg;
    assign turnaround_time = turnaround_reg;
    assign waiting_time    = waiting_reg;
    assign overflow        = overflow_reg;
    assign last_result     = last_result_reg;

endmodule
